### hw/rtl/dseq_pkg.sv
// ----------------------------------------------------------------------------
// dseq_pkg: shared types and helpers of the deadline sorted event queue
// Event count, entry and command types, and the wrapped deadline compare.
// ----------------------------------------------------------------------------
package dseq_pkg;

  localparam int EVENT_COUNT = 32;
  localparam int ID_W        = 5;
  localparam int TIME_W      = 32;
  localparam int MASK_W      = 32;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_POP    = 2'd2,
    OP_REBASE = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_DROP,
    CELL_POP,
    CELL_REBASE,
    CELL_INSERT
  } cell_op_e;

  typedef enum logic {
    ST_IDLE,
    ST_INSERT
  } state_e;

  typedef struct packed {
    logic              valid;
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] deadline;
  } entry_t;

  // broadcast to every cell of the chain
  typedef struct packed {
    cell_op_e          op;
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] deadline;
    logic [TIME_W-1:0] now;
  } cmd_t;

  // signed distance compare: (a - now) < (b - now)
  function automatic logic sooner(input logic [TIME_W-1:0] a,
                                  input logic [TIME_W-1:0] b,
                                  input logic [TIME_W-1:0] now);
    logic [TIME_W-1:0] da;
    logic [TIME_W-1:0] db;
    da = (a - now) ^ {1'b1, {(TIME_W-1){1'b0}}};
    db = (b - now) ^ {1'b1, {(TIME_W-1){1'b0}}};
    return da < db;
  endfunction

endpackage

### hw/rtl/dseq_cell.sv
// ----------------------------------------------------------------------------
// dseq_cell: one slot of the sorted chain
// Holds one queued event and takes data from its left or right neighbor.
// ----------------------------------------------------------------------------
module dseq_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  dseq_pkg::cmd_t   cmd_i,
  input  dseq_pkg::entry_t left_i,
  input  dseq_pkg::entry_t right_i,
  input  logic            flag_i,
  output dseq_pkg::entry_t entry_o,
  output logic            flag_o
);
  import dseq_pkg::*;

  logic              valid_q, valid_d;
  logic [ID_W-1:0]   id_q, id_d;
  logic [TIME_W-1:0] deadline_q, deadline_d;
  logic              match;
  logic              gate;

  assign match = valid_q && (id_q == cmd_i.id);
  // new entry goes in front of this one
  assign gate  = !valid_q || sooner(cmd_i.deadline, deadline_q, cmd_i.now);

  always_comb begin
    flag_o     = flag_i;
    valid_d    = valid_q;
    id_d       = id_q;
    deadline_d = deadline_q;
    case (cmd_i.op)
      CELL_DROP: begin
        flag_o = flag_i | match;
        if (flag_o) begin
          valid_d    = right_i.valid;
          id_d       = right_i.id;
          deadline_d = right_i.deadline;
        end
      end
      CELL_POP: begin
        valid_d    = right_i.valid;
        id_d       = right_i.id;
        deadline_d = right_i.deadline;
      end
      CELL_REBASE: begin
        deadline_d = deadline_q - cmd_i.now;
      end
      CELL_INSERT: begin
        flag_o = flag_i | gate;
        if (flag_i) begin
          valid_d    = left_i.valid;
          id_d       = left_i.id;
          deadline_d = left_i.deadline;
        end else if (gate) begin
          id_d       = cmd_i.id;
          deadline_d = cmd_i.deadline;
          valid_d    = 1'b1;
        end
      end
      default: begin
        flag_o = flag_i;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    id_q       <= id_d;
    deadline_q <= deadline_d;
  end

  always_comb begin
    entry_o.valid    = valid_q;
    entry_o.id       = id_q;
    entry_o.deadline = deadline_q;
  end

endmodule

### hw/rtl/deadline_sorted_event_queue.sv
// ----------------------------------------------------------------------------
// deadline_sorted_event_queue: event queue kept sorted by deadline
// A chain of cells, front at cell 0, updated in place by broadcast commands.
// ----------------------------------------------------------------------------
//  channel  | handshake          | words
//  ---------+--------------------+------------------------------------------
//  command  | start_i / busy_o   | opcode, event_id, delay_cycles, now_cycle
//  result   | done_o (one cycle) | popped_id/valid, front, empty, pending
//
// remove, pop and rebase update the chain at the accepting edge
// add runs a drop pass over the chain, then an insert pass (busy_o high)
// the result strobe is registered after the last pass; while it shows, a new
// command can already be taken; the ripple through all cells sets the clock
// reset empties the chain at once; the result side cannot stall
// ----------------------------------------------------------------------------
module deadline_sorted_event_queue (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic [1:0]                    opcode_i,
  input  logic [dseq_pkg::ID_W-1:0]     event_id_i,
  input  logic [dseq_pkg::TIME_W-1:0]   delay_cycles_i,
  input  logic [dseq_pkg::TIME_W-1:0]   now_cycle_i,
  output logic                          done_o,
  output logic [dseq_pkg::ID_W-1:0]     popped_id_o,
  output logic                          popped_valid_o,
  output logic [dseq_pkg::ID_W-1:0]     front_id_o,
  output logic [dseq_pkg::TIME_W-1:0]   front_deadline_o,
  output logic                          queue_empty_o,
  output logic [dseq_pkg::MASK_W-1:0]   pending_mask_o
);
  import dseq_pkg::*;

  state_e              state_q, state_d;
  logic                done_q, done_d;
  logic [ID_W-1:0]     popped_id_q, popped_id_d;
  logic                popped_valid_q, popped_valid_d;
  logic [MASK_W-1:0]   pending_q, pending_d;
  logic [ID_W-1:0]     add_id_q, add_id_d;
  logic [TIME_W-1:0]   add_deadline_q, add_deadline_d;
  logic [TIME_W-1:0]   add_now_q, add_now_d;

  cmd_t   cmd;
  logic   accept;
  logic   id_ok;
  op_e    op;
  entry_t entries [EVENT_COUNT];
  entry_t lefts   [EVENT_COUNT];
  entry_t rights  [EVENT_COUNT];
  logic   flags   [EVENT_COUNT+1];

  assign op     = op_e'(opcode_i);
  assign accept = start_i && (state_q == ST_IDLE);
  assign id_ok  = (6'(event_id_i) < 6'(EVENT_COUNT));

  always_comb begin
    state_d        = state_q;
    done_d         = 1'b0;
    popped_id_d    = popped_id_q;
    popped_valid_d = popped_valid_q;
    pending_d      = pending_q;
    add_id_d       = add_id_q;
    add_deadline_d = add_deadline_q;
    add_now_d      = add_now_q;
    cmd.op         = CELL_HOLD;
    cmd.id         = event_id_i;
    cmd.deadline   = now_cycle_i + delay_cycles_i;
    cmd.now        = now_cycle_i;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          popped_id_d    = '0;
          popped_valid_d = 1'b0;
          done_d         = 1'b1;
          case (op)
            OP_ADD: begin
              if (id_ok) begin
                // drop any queued copy first
                cmd.op                 = CELL_DROP;
                pending_d[event_id_i]  = 1'b1;
                add_id_d               = event_id_i;
                add_deadline_d         = now_cycle_i + delay_cycles_i;
                add_now_d              = now_cycle_i;
                done_d                 = 1'b0;
                state_d                = ST_INSERT;
              end
            end
            OP_REMOVE: begin
              if (id_ok) begin
                cmd.op                = CELL_DROP;
                pending_d[event_id_i] = 1'b0;
              end
            end
            OP_POP: begin
              if (entries[0].valid) begin
                cmd.op                     = CELL_POP;
                popped_id_d                = entries[0].id;
                popped_valid_d             = 1'b1;
                pending_d[entries[0].id]   = 1'b0;
              end
            end
            OP_REBASE: begin
              cmd.op = CELL_REBASE;
            end
            default: begin
              cmd.op = CELL_HOLD;
            end
          endcase
        end
      end
      ST_INSERT: begin
        cmd.op       = CELL_INSERT;
        cmd.id       = add_id_q;
        cmd.deadline = add_deadline_q;
        cmd.now      = add_now_q;
        done_d       = 1'b1;
        state_d      = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      done_q         <= 1'b0;
      popped_id_q    <= '0;
      popped_valid_q <= 1'b0;
      pending_q      <= '0;
    end else begin
      state_q        <= state_d;
      done_q         <= done_d;
      popped_id_q    <= popped_id_d;
      popped_valid_q <= popped_valid_d;
      pending_q      <= pending_d;
    end
  end

  always_ff @(posedge clk_i) begin
    add_id_q       <= add_id_d;
    add_deadline_q <= add_deadline_d;
    add_now_q      <= add_now_d;
  end

  assign flags[0] = 1'b0;

  for (genvar i = 0; i < EVENT_COUNT; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign lefts[i] = '0;
    end else begin : g_mid
      assign lefts[i] = entries[i-1];
    end
    if (i == EVENT_COUNT-1) begin : g_last
      assign rights[i] = '0;
    end else begin : g_body
      assign rights[i] = entries[i+1];
    end

    dseq_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .cmd_i   (cmd),
      .left_i  (lefts[i]),
      .right_i (rights[i]),
      .flag_i  (flags[i]),
      .entry_o (entries[i]),
      .flag_o  (flags[i+1])
    );
  end

  assign busy_o           = (state_q == ST_INSERT);
  assign done_o           = done_q;
  assign popped_id_o      = popped_id_q;
  assign popped_valid_o   = popped_valid_q;
  assign front_id_o       = entries[0].valid ? entries[0].id : '0;
  assign front_deadline_o = entries[0].valid ? entries[0].deadline : '0;
  assign queue_empty_o    = !entries[0].valid;
  assign pending_mask_o   = pending_q;

endmodule

### hw/rtl/dseq_checker.sv
// ----------------------------------------------------------------------------
// dseq_checker: port level checks of the deadline sorted event queue
// Watches command acceptance, the add sequence and result consistency.
// ----------------------------------------------------------------------------
module dseq_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          start_i,
  input logic                          busy_i,
  input logic [1:0]                    opcode_i,
  input logic                          done_i,
  input logic [dseq_pkg::ID_W-1:0]     popped_id_i,
  input logic                          popped_valid_i,
  input logic [dseq_pkg::TIME_W-1:0]   front_deadline_i,
  input logic                          queue_empty_i,
  input logic [dseq_pkg::MASK_W-1:0]   pending_mask_i
);
  import dseq_pkg::*;

  // the insert pass ends in a result, with busy low, in the next cycle
  a_insert_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_i |=> done_i && !busy_i)
    else $error("add did not finish after its insert pass");

  // single pass words answer in the next cycle
  a_short_op : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_i && (opcode_i != OP_ADD) |=> done_i)
    else $error("missing result for a single pass word");

  a_done_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_i |-> !busy_i)
    else $error("result shown while busy");

  a_pop_cleared : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_i && popped_valid_i |-> !pending_mask_i[popped_id_i])
    else $error("popped event still pending");

  a_empty_clean : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_i && queue_empty_i |-> (front_deadline_i == '0) && (pending_mask_i == '0))
    else $error("empty queue with pending events or a deadline");

endmodule

bind deadline_sorted_event_queue dseq_checker u_dseq_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .start_i          (start_i),
  .busy_i           (busy_o),
  .opcode_i         (opcode_i),
  .done_i           (done_o),
  .popped_id_i      (popped_id_o),
  .popped_valid_i   (popped_valid_o),
  .front_deadline_i (front_deadline_o),
  .queue_empty_i    (queue_empty_o),
  .pending_mask_i   (pending_mask_o)
);
